// File: sv/tape_bit_waveform_encoder_core_macros.svh
// Assertion macros used by the checker file of the tape bit waveform encoder.
// Depends on nothing; include by bare file name.
`ifndef TAPE_BIT_WAVEFORM_ENCODER_CORE_MACROS_SVH
`define TAPE_BIT_WAVEFORM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define TBWE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TBWE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tbwe_pkg.sv
// Package of the tape bit waveform encoder: constants, command and status types,
// waveform table and digit helpers. Depends on nothing.
package tbwe_pkg;

  localparam int WAVE_TABLE_LEN   = 13;
  localparam int ONE_FULL_CYCLES  = 4;
  localparam int ONE_TAIL         = 6;
  localparam int ZERO_FULL_CYCLES = 2;
  localparam int ONE_WAVE_LEN     = ONE_FULL_CYCLES * WAVE_TABLE_LEN + ONE_TAIL;
  localparam int ZERO_WAVE_LEN    = ZERO_FULL_CYCLES * WAVE_TABLE_LEN;
  localparam int CNT_W            = $clog2(ONE_WAVE_LEN);
  localparam int PH_W             = $clog2(WAVE_TABLE_LEN);

  localparam int SAMPLE_W = 8;
  localparam int REP_W    = 8;
  localparam int LEAD_W   = 8;
  localparam int RATE_W   = 7;
  localparam int ACC_W    = 9;
  localparam int SUM_W    = ACC_W + 1;
  localparam int HUND_W   = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [SAMPLE_W-1:0] SILENCE = 8'h80;

  localparam logic [LEAD_W-1:0] LEAD_RESET = 8'd29;
  localparam logic [RATE_W-1:0] RATE_RESET = 7'd76;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_LEAD_ONE  = 2'd0,
    REG_LEAD_ZERO = 2'd1,
    REG_RATE_ONE  = 2'd2,
    REG_RATE_ZERO = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAD,
    ST_WAVE,
    ST_EXTRA
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic emit_lead;
    logic emit_wave;
    logic emit_extra;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic lead_zero;
    logic wave_final;
    logic extra;
  } status_t;

  function automatic logic [SAMPLE_W-1:0] wave_sample(input logic [PH_W-1:0] idx);
    logic [SAMPLE_W-1:0] s;
    unique case (idx)
      4'd0:    s = 8'd128;
      4'd1:    s = 8'd212;
      4'd2:    s = 8'd224;
      4'd3:    s = 8'd153;
      4'd4:    s = 8'd60;
      4'd5:    s = 8'd26;
      4'd6:    s = 8'd81;
      4'd7:    s = 8'd175;
      4'd8:    s = 8'd230;
      4'd9:    s = 8'd196;
      4'd10:   s = 8'd103;
      4'd11:   s = 8'd32;
      4'd12:   s = 8'd44;
      default: s = SILENCE;
    endcase
    return s;
  endfunction

  // Hundreds digit of a value below 700
  function automatic logic [HUND_W-1:0] hundreds(input logic [SUM_W-1:0] v);
    logic [HUND_W-1:0] h;
    priority if (v >= 10'd600) h = 3'd6;
    else if (v >= 10'd500)     h = 3'd5;
    else if (v >= 10'd400)     h = 3'd4;
    else if (v >= 10'd300)     h = 3'd3;
    else if (v >= 10'd200)     h = 3'd2;
    else if (v >= 10'd100)     h = 3'd1;
    else                       h = 3'd0;
    return h;
  endfunction

  function automatic logic [SUM_W-1:0] times100(input logic [HUND_W-1:0] h);
    logic [SUM_W-1:0] r;
    unique case (h)
      3'd0:    r = 10'd0;
      3'd1:    r = 10'd100;
      3'd2:    r = 10'd200;
      3'd3:    r = 10'd300;
      3'd4:    r = 10'd400;
      3'd5:    r = 10'd500;
      3'd6:    r = 10'd600;
      default: r = 10'd700;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tape_bit_waveform_encoder_core.sv
// Tape bit waveform encoder. Each accepted data bit yields an optional silence
// run (sample 128 with a repeat count), then 58 waveform samples for a one or 26
// for a zero, then an optional extra silence sample from that bit's fractional
// accumulator; last marks the final item of the bit. A bit passes through an accept
// step, a lead step, one step per waveform sample and an optional extra step. The
// output register emits one item per cycle while the output side does not stall,
// and the controller handles one bit at a time. Configuration registers sit on an
// APB port at byte addresses 0, 4, 8, 12.
// Depends on tbwe_pkg, tbwe_ctrl and tbwe_dp.
module tape_bit_waveform_encoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_data_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tbwe_pkg::SAMPLE_W-1:0] out_sample,
  output logic [tbwe_pkg::REP_W-1:0]    out_repeat_count,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbwe_pkg::ADDR_W-1:0]   paddr,
  input  logic [tbwe_pkg::DATA_W-1:0]   pwdata,
  output logic [tbwe_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  tbwe_pkg::cmd_t    cmd;
  tbwe_pkg::status_t sts;

  assign pready = 1'b1;

  // Sequence the items of each bit
  tbwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold registers, accumulators and the output item
  tbwe_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_bit      (in_data_bit),
    .cmd              (cmd),
    .sts              (sts),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_repeat_count (out_repeat_count),
    .out_last         (out_last)
  );

endmodule

// File: sv/tbwe_ctrl.sv
// Controller of the tape bit waveform encoder: sequences lead, wave and extra items.
// Depends on tbwe_pkg.
module tbwe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tbwe_pkg::status_t sts,
  output tbwe_pkg::cmd_t    cmd
);

  tbwe_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbwe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tbwe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = tbwe_pkg::ST_LEAD;
        end
      end
      tbwe_pkg::ST_LEAD: begin
        // Skip the silence run when the lead count is zero
        if (sts.lead_zero) begin
          state_nxt = tbwe_pkg::ST_WAVE;
        end else if (sts.out_free) begin
          cmd.emit_lead = 1'b1;
          state_nxt     = tbwe_pkg::ST_WAVE;
        end
      end
      tbwe_pkg::ST_WAVE: begin
        if (sts.out_free) begin
          cmd.emit_wave = 1'b1;
          if (sts.wave_final) begin
            state_nxt = sts.extra ? tbwe_pkg::ST_EXTRA : tbwe_pkg::ST_IDLE;
          end
        end
      end
      tbwe_pkg::ST_EXTRA: begin
        if (sts.out_free) begin
          cmd.emit_extra = 1'b1;
          state_nxt      = tbwe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbwe_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/tbwe_dp.sv
// Datapath of the tape bit waveform encoder: registers, accumulators, wave counter
// and output register. Depends on tbwe_pkg.
module tbwe_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_data_bit,
  input  tbwe_pkg::cmd_t                      cmd,
  output tbwe_pkg::status_t                   sts,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tbwe_pkg::ADDR_W-1:0]         paddr,
  input  logic [tbwe_pkg::DATA_W-1:0]         pwdata,
  output logic [tbwe_pkg::DATA_W-1:0]         prdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tbwe_pkg::SAMPLE_W-1:0]       out_sample,
  output logic [tbwe_pkg::REP_W-1:0]          out_repeat_count,
  output logic                                out_last
);

  logic [tbwe_pkg::LEAD_W-1:0] lead_one_r, lead_zero_r;
  logic [tbwe_pkg::RATE_W-1:0] rate_one_r, rate_zero_r;
  logic [tbwe_pkg::ACC_W-1:0]  acc_one_r, acc_zero_r;
  logic                        bit_r, extra_r;
  logic [tbwe_pkg::LEAD_W-1:0] lead_r;
  logic [tbwe_pkg::CNT_W-1:0]  cnt_r;
  logic [tbwe_pkg::PH_W-1:0]   ph_r;
  logic                        out_valid_r;
  logic [tbwe_pkg::SAMPLE_W-1:0] sample_r;
  logic [tbwe_pkg::REP_W-1:0]  rep_r;
  logic                        last_r;

  logic                        wr_en;
  tbwe_pkg::reg_idx_t          reg_idx;
  logic [tbwe_pkg::RATE_W-1:0] rate;
  logic [tbwe_pkg::ACC_W-1:0]  acc;
  logic [tbwe_pkg::SUM_W-1:0]  sum;
  logic [tbwe_pkg::HUND_W-1:0] old_h, new_h;
  logic                        extra_nxt;
  logic [tbwe_pkg::ACC_W-1:0]  acc_nxt;
  logic                        wave_final;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = tbwe_pkg::reg_idx_t'(paddr[3:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_one_r  <= tbwe_pkg::LEAD_RESET;
      lead_zero_r <= tbwe_pkg::LEAD_RESET;
      rate_one_r  <= tbwe_pkg::RATE_RESET;
      rate_zero_r <= tbwe_pkg::RATE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbwe_pkg::REG_LEAD_ONE:  lead_one_r  <= pwdata[tbwe_pkg::LEAD_W-1:0];
        tbwe_pkg::REG_LEAD_ZERO: lead_zero_r <= pwdata[tbwe_pkg::LEAD_W-1:0];
        tbwe_pkg::REG_RATE_ONE:  rate_one_r  <= pwdata[tbwe_pkg::RATE_W-1:0];
        tbwe_pkg::REG_RATE_ZERO: rate_zero_r <= pwdata[tbwe_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      tbwe_pkg::REG_LEAD_ONE:  prdata = tbwe_pkg::DATA_W'(lead_one_r);
      tbwe_pkg::REG_LEAD_ZERO: prdata = tbwe_pkg::DATA_W'(lead_zero_r);
      tbwe_pkg::REG_RATE_ONE:  prdata = tbwe_pkg::DATA_W'(rate_one_r);
      tbwe_pkg::REG_RATE_ZERO: prdata = tbwe_pkg::DATA_W'(rate_zero_r);
      default:                 prdata = '0;
    endcase
  end

  // Advance the accumulator of the incoming bit value
  always_comb begin
    rate      = in_data_bit ? rate_one_r : rate_zero_r;
    acc       = in_data_bit ? acc_one_r : acc_zero_r;
    sum       = tbwe_pkg::SUM_W'(acc) + tbwe_pkg::SUM_W'(rate);
    old_h     = tbwe_pkg::hundreds(tbwe_pkg::SUM_W'(acc));
    new_h     = tbwe_pkg::hundreds(sum);
    extra_nxt = 1'b0;
    acc_nxt   = acc;
    if (rate != '0) begin
      if (new_h > old_h) begin
        extra_nxt = 1'b1;
        acc_nxt   = tbwe_pkg::ACC_W'(sum - tbwe_pkg::times100(old_h));
      end else begin
        acc_nxt   = sum[tbwe_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_one_r  <= '0;
      acc_zero_r <= '0;
    end else if (cmd.start) begin
      if (in_data_bit) begin
        acc_one_r  <= acc_nxt;
      end else begin
        acc_zero_r <= acc_nxt;
      end
    end
  end

  // Latch the item and step the wave counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bit_r   <= in_data_bit;
      extra_r <= extra_nxt;
      lead_r  <= in_data_bit ? lead_one_r : lead_zero_r;
      cnt_r   <= '0;
      ph_r    <= '0;
    end else if (cmd.emit_wave) begin
      cnt_r <= cnt_r + 1'b1;
      ph_r  <= (ph_r == tbwe_pkg::PH_W'(tbwe_pkg::WAVE_TABLE_LEN - 1)) ? '0 : ph_r + 1'b1;
    end
  end

  assign wave_final = bit_r ? (cnt_r == tbwe_pkg::CNT_W'(tbwe_pkg::ONE_WAVE_LEN - 1))
                            : (cnt_r == tbwe_pkg::CNT_W'(tbwe_pkg::ZERO_WAVE_LEN - 1));

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_lead || cmd.emit_wave || cmd.emit_extra) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_lead) begin
      sample_r <= tbwe_pkg::SILENCE;
      rep_r    <= lead_r;
      last_r   <= 1'b0;
    end else if (cmd.emit_wave) begin
      sample_r <= tbwe_pkg::wave_sample(ph_r);
      rep_r    <= tbwe_pkg::REP_W'(1);
      last_r   <= wave_final && !extra_r;
    end else if (cmd.emit_extra) begin
      sample_r <= tbwe_pkg::SILENCE;
      rep_r    <= tbwe_pkg::REP_W'(1);
      last_r   <= 1'b1;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.lead_zero  = (lead_r == '0);
  assign sts.wave_final = wave_final;
  assign sts.extra      = extra_r;

  assign out_valid        = out_valid_r;
  assign out_sample       = sample_r;
  assign out_repeat_count = rep_r;
  assign out_last         = last_r;

endmodule

// File: sv/tbwe_checker.sv
// Port-level checker of the tape bit waveform encoder and its bind.
// Depends on tbwe_pkg and tape_bit_waveform_encoder_core_macros.svh.
`include "tape_bit_waveform_encoder_core_macros.svh"

module tbwe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tbwe_pkg::SAMPLE_W-1:0] out_sample,
  input logic [tbwe_pkg::REP_W-1:0]    out_repeat_count,
  input logic                          out_last
);

  // A stalled item holds
  `TBWE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_repeat_count) && $stable(out_last), "stalled output item changed")
  // One bit at a time: busy right after an accept
  `TBWE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted on consecutive cycles")
  // Only silence carries a repeat count above one
  `TBWE_ASSERT_IMPLY(a_rep_wave, clk, rst_n, out_valid && (out_sample != tbwe_pkg::SILENCE), out_repeat_count == tbwe_pkg::REP_W'(1), "waveform sample repeated")
  // Never a zero repeat count
  `TBWE_ASSERT_IMPLY(a_rep_nonzero, clk, rst_n, out_valid, out_repeat_count != '0, "zero repeat count")

endmodule

bind tape_bit_waveform_encoder_core tbwe_checker u_tbwe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sample       (out_sample),
  .out_repeat_count (out_repeat_count),
  .out_last         (out_last)
);
